// ===== design/enc_sa_pkg.sv =====
// Shared types and constants for the encoder soft acceleration block.
// No dependencies; used by enc_sa_cfg, enc_sa_core and the top level.
`timescale 1ns / 1ps

package enc_sa_pkg;

  localparam int POS_W      = 18;
  localparam int TIME_W     = 32;
  localparam int STEP_W     = 19;
  localparam int REM_W      = 16;
  localparam int MS_W       = 16;
  localparam int MAXSTEP_W  = 8;
  localparam int CFG_GAIN_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Small-path deltas are bounded by max_step, so 9 signed bits hold them.
  localparam int SMALL_W = MAXSTEP_W + 1;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic [MS_W-1:0]       RESET_MS_RST    = 16'd400;
  localparam logic [MAXSTEP_W-1:0]  MAX_STEP_RST    = 8'd6;
  localparam logic [MS_W-1:0]       FAST_MS_RST     = 16'd40;
  localparam logic [MS_W-1:0]       MEDIUM_MS_RST   = 16'd100;
  localparam logic [MS_W-1:0]       SLOW_MS_RST     = 16'd180;
  localparam logic [CFG_GAIN_W-1:0] FAST_GAIN_RST   = 10'd512;
  localparam logic [CFG_GAIN_W-1:0] MEDIUM_GAIN_RST = 10'd410;
  localparam logic [CFG_GAIN_W-1:0] SLOW_GAIN_RST   = 10'd333;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_MS    = 3'd0,
    CFG_MAX_STEP    = 3'd1,
    CFG_FAST_MS     = 3'd2,
    CFG_MEDIUM_MS   = 3'd3,
    CFG_SLOW_MS     = 3'd4,
    CFG_FAST_GAIN   = 3'd5,
    CFG_MEDIUM_GAIN = 3'd6,
    CFG_SLOW_GAIN   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MS_W-1:0]       reset_ms;
    logic [MAXSTEP_W-1:0]  max_step;
    logic [MS_W-1:0]       fast_ms;
    logic [MS_W-1:0]       medium_ms;
    logic [MS_W-1:0]       slow_ms;
    logic [CFG_GAIN_W-1:0] fast_gain;
    logic [CFG_GAIN_W-1:0] medium_gain;
    logic [CFG_GAIN_W-1:0] slow_gain;
  } cfg_t;

  // What kind of item the core just took.
  typedef struct packed {
    logic zero;   // delta was zero, step forced to 0
    logic accel;  // accelerated path
  } acc_stat_t;

endpackage

// ===== design/encoder_soft_acceleration.sv =====
// Top level of the encoder soft acceleration block: input register, core,
// result register. Depends on enc_sa_pkg, enc_sa_cfg and enc_sa_core.
//
//  channel | dir | handshake              | contents
//  s_      | in  | s_tvalid / s_tready    | position, time_ms
//  m_      | out | m_tvalid / m_tready    | step
//  cfg_    | in  | cfg_wen                | register index, write data
//
// One item per clock unless m_ stalls; input register, then result register.
// The throughput is set by the combinational core: one small multiply, add,
// round and clamp feed the carried remainder before the next item.
// Synchronous reset clears both stage valids and carried state and presets config.
// A stall on m_ backs up through the input register to s_tready.
`timescale 1ns / 1ps

module encoder_soft_acceleration #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [17:0] position, [49:18] time_ms, [55:50] unused
  input  logic [enc_sa_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [18:0] step, [23:19] zero
  output logic [enc_sa_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                  cfg_wen,
  input  logic [enc_sa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [enc_sa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  enc_sa_pkg::cfg_t                      cfg;
  enc_sa_pkg::acc_stat_t                 stat;
  logic                                  in_valid;
  logic signed [enc_sa_pkg::POS_W-1:0]   pos_q;
  logic [enc_sa_pkg::TIME_W-1:0]         time_q;
  logic                                  adv;
  logic                                  fire;
  logic signed [enc_sa_pkg::STEP_W-1:0]  step_next;
  logic signed [enc_sa_pkg::STEP_W-1:0]  step_q;
  logic signed [enc_sa_pkg::STEP_W-1:0]  mx_ext;

  enc_sa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  enc_sa_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .position  (pos_q),
    .time_ms   (time_q),
    .cfg       (cfg),
    .step_next (step_next),
    .stat      (stat)
  );

  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        pos_q    <= s_tdata[enc_sa_pkg::POS_W-1:0];
        time_q   <= s_tdata[enc_sa_pkg::POS_W +: enc_sa_pkg::TIME_W];
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
        step_q   <= step_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(enc_sa_pkg::OUT_TDATA_W - enc_sa_pkg::STEP_W){1'b0}}, step_q};
  assign mx_ext  = enc_sa_pkg::STEP_W'(cfg.max_step);

  // Input register must hold while the result register is stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while stage is blocked");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed item produced no result");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    fire && stat.zero |=> step_q == '0)
    else $error("zero delta gave nonzero step");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    fire && stat.accel |=> step_q != '0 && step_q <= $past(mx_ext) && step_q >= -$past(mx_ext))
    else $error("accelerated step outside +-max_step or zero");

endmodule

// ===== design/enc_sa_cfg.sv =====
// Configuration register file for the encoder soft acceleration block.
// Depends on enc_sa_pkg.
`timescale 1ns / 1ps

module enc_sa_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [enc_sa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [enc_sa_pkg::CFG_DATA_W-1:0] cfg_data,
  output enc_sa_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_ms    <= enc_sa_pkg::RESET_MS_RST;
      cfg.max_step    <= enc_sa_pkg::MAX_STEP_RST;
      cfg.fast_ms     <= enc_sa_pkg::FAST_MS_RST;
      cfg.medium_ms   <= enc_sa_pkg::MEDIUM_MS_RST;
      cfg.slow_ms     <= enc_sa_pkg::SLOW_MS_RST;
      cfg.fast_gain   <= enc_sa_pkg::FAST_GAIN_RST;
      cfg.medium_gain <= enc_sa_pkg::MEDIUM_GAIN_RST;
      cfg.slow_gain   <= enc_sa_pkg::SLOW_GAIN_RST;
    end else if (cfg_wen) begin
      case (enc_sa_pkg::cfg_idx_t'(cfg_index))
        enc_sa_pkg::CFG_RESET_MS:    cfg.reset_ms    <= cfg_data;
        enc_sa_pkg::CFG_MAX_STEP:    cfg.max_step    <= cfg_data[enc_sa_pkg::MAXSTEP_W-1:0];
        enc_sa_pkg::CFG_FAST_MS:     cfg.fast_ms     <= cfg_data;
        enc_sa_pkg::CFG_MEDIUM_MS:   cfg.medium_ms   <= cfg_data;
        enc_sa_pkg::CFG_SLOW_MS:     cfg.slow_ms     <= cfg_data;
        enc_sa_pkg::CFG_FAST_GAIN:   cfg.fast_gain   <= cfg_data[enc_sa_pkg::CFG_GAIN_W-1:0];
        enc_sa_pkg::CFG_MEDIUM_GAIN: cfg.medium_gain <= cfg_data[enc_sa_pkg::CFG_GAIN_W-1:0];
        enc_sa_pkg::CFG_SLOW_GAIN:   cfg.slow_gain   <= cfg_data[enc_sa_pkg::CFG_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/enc_sa_core.sv =====
// Acceleration datapath and carried state (last position, last event time,
// fractional remainder). Depends on enc_sa_pkg.
`timescale 1ns / 1ps

module enc_sa_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic signed [enc_sa_pkg::POS_W-1:0] position,
  input  logic [enc_sa_pkg::TIME_W-1:0]       time_ms,
  input  enc_sa_pkg::cfg_t                    cfg,
  output logic signed [enc_sa_pkg::STEP_W-1:0] step_next,
  output enc_sa_pkg::acc_stat_t               stat
);

  // Unity gain must fit alongside the configured gains.
  localparam int GAIN_W = (FRAC_BITS + 1 > enc_sa_pkg::CFG_GAIN_W) ?
                          FRAC_BITS + 1 : enc_sa_pkg::CFG_GAIN_W;
  localparam int SW = enc_sa_pkg::SMALL_W + GAIN_W + 2;
  localparam int RW = SW + 1;
  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(2 ** FRAC_BITS);
  localparam logic signed [RW-1:0] REM_HI = RW'(2 ** (enc_sa_pkg::REM_W - 1) - 1);
  localparam logic signed [RW-1:0] REM_LO = -REM_HI - RW'(1);

  logic signed [enc_sa_pkg::POS_W-1:0]  prev_position;
  logic [enc_sa_pkg::TIME_W-1:0]        prev_event_ms;
  logic signed [enc_sa_pkg::REM_W-1:0]  remainder;

  logic signed [enc_sa_pkg::STEP_W-1:0] delta;
  logic signed [enc_sa_pkg::STEP_W-1:0] mx19;
  logic                                 big;
  logic [enc_sa_pkg::TIME_W-1:0]        elapsed;
  logic [GAIN_W-1:0]                    gain;
  logic signed [enc_sa_pkg::REM_W-1:0]  rem_in;
  logic signed [SW-1:0]                 d_s, g_s, r_s, scaled;
  logic signed [SW-1:0]                 acc_tz, acc_fin, mx_s;
  logic signed [RW-1:0]                 rem_full;
  logic signed [enc_sa_pkg::REM_W-1:0]  rem_sat;

  always_comb begin
    delta = enc_sa_pkg::STEP_W'(position) - enc_sa_pkg::STEP_W'(prev_position);
    mx19  = enc_sa_pkg::STEP_W'(cfg.max_step);
    big   = (delta > mx19) || (delta < -mx19);

    elapsed = time_ms - prev_event_ms;
    rem_in  = (elapsed > enc_sa_pkg::TIME_W'(cfg.reset_ms)) ? '0 : remainder;

    if (elapsed <= enc_sa_pkg::TIME_W'(cfg.fast_ms))        gain = GAIN_W'(cfg.fast_gain);
    else if (elapsed <= enc_sa_pkg::TIME_W'(cfg.medium_ms)) gain = GAIN_W'(cfg.medium_gain);
    else if (elapsed <= enc_sa_pkg::TIME_W'(cfg.slow_ms))   gain = GAIN_W'(cfg.slow_gain);
    else                                                    gain = UNITY;

    // Small path: |delta| <= max_step, so the low bits hold it exactly.
    d_s    = SW'($signed(delta[enc_sa_pkg::SMALL_W-1:0]));
    g_s    = SW'(gain);
    r_s    = SW'(rem_in);
    scaled = d_s * g_s + r_s;

    // Arithmetic shift floors; bump negatives with a nonzero fraction.
    acc_tz = (scaled >>> FRAC_BITS) +
             $signed(SW'(scaled[SW-1] && (scaled[FRAC_BITS-1:0] != '0)));
    if (acc_tz == '0) acc_tz = delta[enc_sa_pkg::STEP_W-1] ? -SW'(1) : SW'(1);

    mx_s = SW'(cfg.max_step);
    if (acc_tz > mx_s)       acc_fin = mx_s;
    else if (acc_tz < -mx_s) acc_fin = -mx_s;
    else                     acc_fin = acc_tz;

    // Clamp excess lands in the remainder automatically.
    rem_full = RW'(scaled) - (RW'(acc_fin) <<< FRAC_BITS);
    if (rem_full > REM_HI)      rem_sat = enc_sa_pkg::REM_W'(REM_HI);
    else if (rem_full < REM_LO) rem_sat = enc_sa_pkg::REM_W'(REM_LO);
    else                        rem_sat = rem_full[enc_sa_pkg::REM_W-1:0];

    stat.zero  = (delta == '0);
    stat.accel = !stat.zero && !big;

    if (stat.zero)  step_next = '0;
    else if (big)   step_next = delta;
    else            step_next = acc_fin[enc_sa_pkg::STEP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_position <= '0;
      prev_event_ms <= '0;
      remainder     <= '0;
    end else if (fire && !stat.zero) begin
      prev_position <= position;
      if (big) begin
        remainder <= '0;
      end else begin
        prev_event_ms <= time_ms;
        remainder     <= rem_sat;
      end
    end
  end

endmodule
